@@ design/camera_blockage_decision_fsm_macros.svh @@
// assertion macros shared by the camera blockage decision design
`ifndef CAMERA_BLOCKAGE_DECISION_FSM_MACROS_SVH
`define CAMERA_BLOCKAGE_DECISION_FSM_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define CBD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// next-cycle implication, checked out of reset
`define CBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define CBD_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define CBD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ design/cbd_pkg.sv @@
// shared types, constants and helpers for the camera blockage decision block
`timescale 1ns / 1ps

package cbd_pkg;

  localparam int unsigned ACC_W     = 24;
  localparam int unsigned VERDICT_W = 2;
  localparam int unsigned TSTEP_W   = 10;
  localparam int unsigned DSTEP_W   = 12;
  localparam int unsigned DEC_W     = 2;
  localparam int unsigned CFG_IDX_W = 3;

  // verdict codes
  localparam logic [VERDICT_W-1:0] VERDICT_CLEAR   = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_BLOCKED = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_COND    = 2'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_INVALID = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_DIST   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_INPUT_DIST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_INPUT_TIME = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNBLOCK_DELAY = 3'd3;

  // configuration reset values
  localparam logic [ACC_W-1:0] SETTLE_DIST_RST   = 24'd5000;
  localparam logic [ACC_W-1:0] NO_INPUT_DIST_RST = 24'd50000;
  localparam logic [ACC_W-1:0] NO_INPUT_TIME_RST = 24'd30000;
  localparam logic [ACC_W-1:0] UNBLOCK_DELAY_RST = 24'd2000;

  typedef struct packed {
    logic [ACC_W-1:0] settle_distance;
    logic [ACC_W-1:0] no_input_distance;
    logic [ACC_W-1:0] no_input_time;
    logic [ACC_W-1:0] unblock_delay;
  } cfg_t;

  // saturating accumulate, clamps at all ones
  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
                                                input logic [ACC_W-1:0] inc);
    logic [ACC_W:0] sum;
    sum = {1'b0, acc} + {1'b0, inc};
    return sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
  endfunction

endpackage

@@ design/cbd_cfg_regs.sv @@
// configuration register file for the camera blockage decision block
`timescale 1ns / 1ps

module cbd_cfg_regs
  import cbd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ACC_W-1:0]     cfg_wdata,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // writes are always taken, unknown indexes are dropped
  assign cfg_ready = 1'b1;

  // register decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_SETTLE_DIST:   cfg_nxt.settle_distance   = cfg_wdata;
        CFG_NO_INPUT_DIST: cfg_nxt.no_input_distance = cfg_wdata;
        CFG_NO_INPUT_TIME: cfg_nxt.no_input_time     = cfg_wdata;
        CFG_UNBLOCK_DELAY: cfg_nxt.unblock_delay     = cfg_wdata;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  // register storage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.settle_distance   <= SETTLE_DIST_RST;
      cfg_r.no_input_distance <= NO_INPUT_DIST_RST;
      cfg_r.no_input_time     <= NO_INPUT_TIME_RST;
      cfg_r.unblock_delay     <= UNBLOCK_DELAY_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ design/camera_blockage_decision_fsm.sv @@
// camera blockage decision: top level with input stage, decision logic and result register
//
// Usage:
//   in_*   : one transaction per camera frame carrying the verdict, the frame time
//            step (ms) and the distance step (cm), valid/ready handshake.
//   out_*  : one transaction per input transaction carrying the new decision and the
//            no-valid-input error flag, valid/ready handshake.
//   cfg_*  : register writes (index, 24-bit data), always accepted; write only while
//            no transaction is in flight.
// The input register takes the transaction, the result register loads it once the
// receiver is free, with the decision and accumulator update done in between.
// Throughput is one transaction per cycle while the receiver takes results; the single
// decision stage with its state feedback is what sets it.
// A stalled receiver holds the result register; the input register still takes one
// more transaction, after which in_ready drops until the result is taken.
// Reset (synchronous, active low) returns the decision to clearance measuring, clears
// all accumulators and loads the register defaults.
`timescale 1ns / 1ps
`include "camera_blockage_decision_fsm_macros.svh"

module camera_blockage_decision_fsm
  import cbd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ACC_W-1:0]     cfg_wdata,
  // input transactions
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [VERDICT_W-1:0] in_verdict,
  input  logic [TSTEP_W-1:0]   in_time_step,
  input  logic [DSTEP_W-1:0]   in_distance_step,
  // result transactions
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DEC_W-1:0]     out_decision,
  output logic                 out_no_input_error
);

  typedef enum logic [DEC_W-1:0] {
    MODE_MEAS    = 2'd0,
    MODE_CLEAR   = 2'd1,
    MODE_BLOCKED = 2'd2,
    MODE_COND    = 2'd3
  } mode_t;

  cfg_t cfg;

  logic                 s1_valid_r;
  logic [VERDICT_W-1:0] s1_verdict_r;
  logic [TSTEP_W-1:0]   s1_time_r;
  logic [DSTEP_W-1:0]   s1_dist_r;

  mode_t            mode_r, mode_nxt;
  logic [ACC_W-1:0] elapsed_r, elapsed_nxt;
  logic [ACC_W-1:0] driven_r, driven_nxt;
  logic [ACC_W-1:0] dwell_r, dwell_nxt;
  logic             err_nxt;

  logic             out_valid_r;
  logic [DEC_W-1:0] out_decision_r;
  logic             out_error_r;

  logic out_free;
  logic in_fire;
  logic s1_fire;
  logic settled;
  logic [ACC_W-1:0] tstep_ext;
  logic [ACC_W-1:0] dstep_ext;

  cbd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // handshake and stage advance
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || out_free;
  assign in_fire  = in_valid && in_ready;
  assign s1_fire  = s1_valid_r && out_free;

  assign tstep_ext = {{(ACC_W-TSTEP_W){1'b0}}, s1_time_r};
  assign dstep_ext = {{(ACC_W-DSTEP_W){1'b0}}, s1_dist_r};
  assign settled   = (driven_r >= cfg.settle_distance);

  // decision step
  always_comb begin
    mode_nxt    = mode_r;
    elapsed_nxt = elapsed_r;
    driven_nxt  = driven_r;
    dwell_nxt   = dwell_r;
    err_nxt     = 1'b0;
    case (mode_r)
      MODE_MEAS: begin
        if (s1_verdict_r == VERDICT_CLEAR && settled) begin
          mode_nxt = MODE_CLEAR;
        end else if (s1_verdict_r == VERDICT_BLOCKED) begin
          mode_nxt = MODE_BLOCKED;
        end else if (s1_verdict_r == VERDICT_COND && settled) begin
          mode_nxt = MODE_COND;
        end else if (driven_r > cfg.no_input_distance &&
                     elapsed_r > cfg.no_input_time) begin
          err_nxt = 1'b1;
        end else begin
          elapsed_nxt = sat_add(elapsed_r, tstep_ext);
          driven_nxt  = sat_add(driven_r, dstep_ext);
        end
      end
      MODE_CLEAR: begin
        if (s1_verdict_r == VERDICT_BLOCKED) begin
          mode_nxt = MODE_BLOCKED;
        end else if (s1_verdict_r == VERDICT_COND) begin
          mode_nxt = MODE_COND;
        end
      end
      MODE_BLOCKED: begin
        if (s1_verdict_r == VERDICT_CLEAR || s1_verdict_r == VERDICT_COND) begin
          if (dwell_r > cfg.unblock_delay) begin
            mode_nxt  = (s1_verdict_r == VERDICT_CLEAR) ? MODE_CLEAR : MODE_COND;
            dwell_nxt = '0;
          end else begin
            dwell_nxt = sat_add(dwell_r, tstep_ext);
          end
        end else begin
          dwell_nxt = '0;
        end
      end
      MODE_COND: begin
        if (s1_verdict_r == VERDICT_CLEAR) begin
          mode_nxt = MODE_CLEAR;
        end else if (s1_verdict_r == VERDICT_BLOCKED) begin
          mode_nxt = MODE_BLOCKED;
        end
      end
      default: begin
        mode_nxt = MODE_MEAS;
      end
    endcase
  end

  // state, input register and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      mode_r      <= MODE_MEAS;
      elapsed_r   <= '0;
      driven_r    <= '0;
      dwell_r     <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (in_fire) begin
        s1_verdict_r <= in_verdict;
        s1_time_r    <= in_time_step;
        s1_dist_r    <= in_distance_step;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_fire) begin
        mode_r         <= mode_nxt;
        elapsed_r      <= elapsed_nxt;
        driven_r       <= driven_nxt;
        dwell_r        <= dwell_nxt;
        out_decision_r <= mode_nxt;
        out_error_r    <= err_nxt;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_decision       = out_decision_r;
  assign out_no_input_error = out_error_r;

  // checks
  `CBD_ASSERT_IMPLY(a_err_only_measuring, clk, rst_n,
                    out_valid_r && out_error_r, out_decision_r == MODE_MEAS)
  `CBD_ASSERT_IMPLY(a_dwell_only_blocked, clk, rst_n,
                    mode_r != MODE_BLOCKED, dwell_r == '0)
  `CBD_ASSERT_NEXT(a_state_holds_idle, clk, rst_n,
                   !s1_fire, $stable(mode_r) && $stable(elapsed_r) && $stable(driven_r))
  `CBD_ASSERT_NEXT(a_err_freezes_acc, clk, rst_n,
                   s1_fire && err_nxt, $stable(elapsed_r) && $stable(driven_r))

endmodule
